/* hw/rtl/its_pkg.sv */
// Shared types, constants and the key ordering function for the index tracking sorter.
`default_nettype none

package its_pkg;

  localparam int KEY_W         = 32;
  localparam int IDX_W         = 5;
  localparam int MAX_ITEMS_DEF = 32;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // write the accepted key into the store
    logic start;  // open a sort pass: latch count, direction, flag; clear cells
    logic read;   // read the next stored key toward the insertion row
    logic shift;  // result taken: advance the cell row by one
  } its_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic rd_last;    // the read in progress is the final one of the set
    logic emit_last;  // the head cell holds the final result of the set
  } its_status_t;

  // True when key a leaves strictly before key b.
  function automatic logic its_before(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic             desc);
    logic gt;
    logic lt;
    gt = $signed(a) > $signed(b);
    lt = $signed(a) < $signed(b);
    return desc ? gt : lt;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/its_ram.sv */
// Generic single write port RAM with registered read.
`default_nettype none

module its_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/its_ctrl.sv */
// Controller state machine for the index tracking sorter.
`default_nettype none

module its_ctrl import its_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        is_last,
  input  wire logic        out_stall,
  input  wire its_status_t status,
  output logic             in_stall,
  output logic             out_valid,
  output its_cmd_t         cmd
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SORT  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_acc;
  logic       out_acc;

  assign in_stall  = (state != ST_LOAD);
  assign out_valid = (state == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        cmd.load = in_acc;
        if (in_acc && is_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_SORT;
      end
      ST_SORT: begin
        cmd.read = 1'b1;
        if (status.rd_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last key read lands in the row this cycle
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.shift = out_acc;
        if (out_acc && status.emit_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/its_datapath.sv */
// Datapath: key store, load counter, and the insertion cell row that orders the keys.
`default_nettype none

module its_datapath import its_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire its_cmd_t         cmd,
  input  wire logic             sort_descending,
  input  wire logic [KEY_W-1:0] key_value,
  output its_status_t           status,
  output logic      [KEY_W-1:0] sorted_key,
  output logic      [IDX_W-1:0] original_index,
  output logic                  last_result,
  output logic                  overflowed
);

  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CNTW = $clog2(MAX_ITEMS + 1);

  logic [CNTW-1:0]  load_count;
  logic             ovf;
  logic             full;
  logic [CNTW-1:0]  n_reg;
  logic             dir;
  logic             ovf_out;
  logic [AW-1:0]    rd_ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [KEY_W-1:0] rd_key;
  logic [AW-1:0]    em_cnt;

  logic [KEY_W-1:0] key_c  [MAX_ITEMS];
  logic [IDX_W-1:0] idx_c  [MAX_ITEMS];
  logic             vld_c  [MAX_ITEMS];
  logic             ins    [MAX_ITEMS];
  logic             ins_dn [MAX_ITEMS];
  logic [KEY_W-1:0] key_dn [MAX_ITEMS];
  logic [IDX_W-1:0] idx_dn [MAX_ITEMS];
  logic             vld_dn [MAX_ITEMS];
  logic [KEY_W-1:0] key_up [MAX_ITEMS];
  logic [IDX_W-1:0] idx_up [MAX_ITEMS];
  logic             vld_up [MAX_ITEMS];

  assign full = (load_count == CNTW'(MAX_ITEMS));

  its_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_key_store (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (load_count[AW-1:0]),
    .wdata (key_value),
    .raddr (rd_ptr),
    .rdata (rd_key)
  );

  // Load counter and overflow flag; both clear when a sort pass opens.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      ovf        <= 1'b0;
    end else if (cmd.start) begin
      load_count <= '0;
      ovf        <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        load_count <= load_count + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_reg   <= load_count;
      dir     <= sort_descending;
      ovf_out <= ovf;
      rd_ptr  <= '0;
      em_cnt  <= '0;
    end else begin
      if (cmd.read) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (cmd.shift) begin
        em_cnt <= em_cnt + AW'(1);
      end
    end
    rd_idx <= IDX_W'(rd_ptr);
  end

  assign status.rd_last   = (CNTW'(rd_ptr) == n_reg - CNTW'(1));
  assign status.emit_last = (CNTW'(em_cnt) == n_reg - CNTW'(1));

  // Insert marks form a suffix of the row: empty cells and cells the new key beats.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      ins[i] = !vld_c[i] || its_before(rd_key, key_c[i], dir);
    end
    ins_dn[0] = 1'b0;
    key_dn[0] = '0;
    idx_dn[0] = '0;
    vld_dn[0] = 1'b0;
    for (int i = 1; i < MAX_ITEMS; i++) begin
      ins_dn[i] = ins[i-1];
      key_dn[i] = key_c[i-1];
      idx_dn[i] = idx_c[i-1];
      vld_dn[i] = vld_c[i-1];
    end
    for (int i = 0; i < MAX_ITEMS - 1; i++) begin
      key_up[i] = key_c[i+1];
      idx_up[i] = idx_c[i+1];
      vld_up[i] = vld_c[i+1];
    end
    key_up[MAX_ITEMS-1] = '0;
    idx_up[MAX_ITEMS-1] = '0;
    vld_up[MAX_ITEMS-1] = 1'b0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (rst || cmd.start) begin
        vld_c[i] <= 1'b0;
      end else if (rd_vld && ins[i]) begin
        vld_c[i] <= ins_dn[i] ? vld_dn[i] : 1'b1;
      end else if (cmd.shift) begin
        vld_c[i] <= vld_up[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (rd_vld && ins[i]) begin
        key_c[i] <= ins_dn[i] ? key_dn[i] : rd_key;
        idx_c[i] <= ins_dn[i] ? idx_dn[i] : rd_idx;
      end else if (cmd.shift) begin
        key_c[i] <= key_up[i];
        idx_c[i] <= idx_up[i];
      end
    end
  end

  assign sorted_key     = key_c[0];
  assign original_index = idx_c[0];
  assign last_result    = status.emit_last;
  assign overflowed     = ovf_out;

endmodule

`default_nettype wire

/* hw/rtl/index_tracking_integer_sorter.sv */
// Top level of the index tracking integer sorter: stable sort of signed keys with arrival index.
// Keys load one per cycle while input is open; after the last key the pass opens, stored keys
// are read into the row, a flush follows and results drain; input reopens after the final result.
// The single read port of the key store feeds the insertion row one key per cycle.
// Reset (synchronous, active high) empties the set, clears ovf, sets sort_descending to 1.
`default_nettype none

module index_tracking_integer_sorter import its_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  // key input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] key_value,
  input  wire logic             is_last,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [KEY_W-1:0] sorted_key,
  output logic      [IDX_W-1:0] original_index,
  output logic                  last_result,
  output logic                  overflowed
);

  logic        sort_descending;
  logic        cfg_wr;
  its_cmd_t    cmd;
  its_status_t status;

  // Register map: one register, sort_descending, at byte address 0.
  // Bit 2 of the address selects the register word; anything else reads zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, sort_descending} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_descending <= 1'b1;
    end else if (cfg_wr) begin
      sort_descending <= pwdata[0];
    end
  end

  // Controller sequences load, sort pass and result drain; the datapath holds
  // the key store and the insertion row. Direction is taken when the pass opens.
  its_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  its_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sort_descending (sort_descending),
    .key_value       (key_value),
    .status          (status),
    .sorted_key      (sorted_key),
    .original_index  (original_index),
    .last_result     (last_result),
    .overflowed      (overflowed)
  );

  // Loading and emitting never overlap.
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while results pending");

  // The last key of a set closes the input at once.
  a_last_closes_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_last) |=> in_stall)
    else $error("input still open after last key");

  // Once the final result is taken, the result channel goes quiet and input reopens.
  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_result) |=> (!out_valid && !in_stall))
    else $error("run did not end after final result");

endmodule

`default_nettype wire
